### rtl/lcgsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgsh_pkg
// Shared types and constants of the combined LCG generator with shuffle table.
// ----------------------------------------------------------------------------
package lcgsh_pkg;

  localparam int unsigned WORD_W = 31;
  typedef logic [WORD_W-1:0] word_t;

  // generator A: x <- MUL_A * x mod MOD_A
  localparam word_t       MOD_A  = 31'd2147483563;
  localparam logic [15:0] MUL_A  = 16'd40014;
  // 2^31 mod MOD_A
  localparam logic [7:0]  FOLD_A = 8'd85;

  // generator B: y <- MUL_B * y mod MOD_B
  localparam word_t       MOD_B  = 31'd2147483399;
  localparam logic [15:0] MUL_B  = 16'd40692;
  // 2^31 mod MOD_B
  localparam logic [7:0]  FOLD_B = 8'd249;

  localparam word_t IMM1   = 31'd2147483562;
  localparam word_t B_SEED = 31'd123456789;

  // A steps run before the table fill starts
  localparam int unsigned WARMUP = 8;

endpackage

### rtl/combined_lcg_shuffle_random.sv
`timescale 1ns / 1ps
// Timing: a draw item runs through the DRAW state to the output register; the next
// item is taken only once the sequencer is back in IDLE after the index update.
// A reseed item runs SEED_MUL and SEED_RED for each of TABLE_SIZE+8 steps of
// generator A, then IDX, ISSUE and a draw; a full output holds a draw in HOLD.
// Reset: synchronous, active low; generators load 1 and 123456789, the table
// reads as all zeros at once.
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_random
// Two combined multiplicative congruential generators with a shuffle table;
// one integer deviate per input item.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_random #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  lcgsh_pkg::word_t in_seed,
  output logic             out_valid,
  input  logic             out_stall,
  output lcgsh_pkg::word_t out_deviate
);
  import lcgsh_pkg::*;

  localparam int unsigned IW     = $clog2(TABLE_SIZE);
  localparam int unsigned CW     = $clog2(TABLE_SIZE + WARMUP);
  localparam logic [63:0] NDIV   = 64'd1 + (64'(IMM1) / 64'(TABLE_SIZE));
  localparam int unsigned SH     = 31 + $clog2(NDIV);
  localparam logic [63:0] RECIP  = ((64'd1 << SH) + NDIV - 64'd1) / NDIV;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_IDX,
    ST_ISSUE,
    ST_DRAW,
    ST_HOLD
  } state_t;

  state_t          state_r, state_nxt;
  word_t           a_r, a_nxt;
  word_t           b_r, b_nxt;
  word_t           last_r, last_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            reseed_r, reseed_nxt;
  logic            out_valid_r, out_valid_nxt;
  word_t           out_deviate_r;
  word_t           pend_r;

  word_t           a_step;
  word_t           b_step;
  word_t           rd_data;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  word_t           wr_data;

  logic            in_accept;
  logic            out_free;
  logic [32:0]     diff;
  word_t           result;
  word_t           seed_eff;
  logic [63:0]     idx_prod;
  logic [63:0]     idx_full;
  logic            load_out;
  word_t           load_val;

  lcgsh_step u_step (
    .clk   (clk),
    .a_in  (a_r),
    .b_in  (b_r),
    .a_out (a_step),
    .b_out (b_step)
  );

  lcgsh_table #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (idx_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign seed_eff  = (in_seed == '0) ? 31'd1 : in_seed;

  // deviate: slot minus B, wrapped into 1..IMM1
  always_comb begin
    diff = {2'b00, rd_data} - {2'b00, b_step};
    if ($signed(diff) < 33'sd1) begin
      diff = diff + {2'b00, IMM1};
    end
    result = diff[30:0];
  end

  // table index from the last deviate (after a reseed, the last A value) by reciprocal multiply, then clamp
  always_comb begin
    idx_prod = {33'd0, last_r} * RECIP;
    idx_full = idx_prod >> SH;
    if (idx_full >= 64'(TABLE_SIZE)) begin
      idx_nxt = IW'(TABLE_SIZE - 1);
    end else begin
      idx_nxt = idx_full[IW-1:0];
    end
  end

  // table writes: fill during reseed, replace the drawn slot on a draw
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = a_step;
    if (state_r == ST_SEED_RED && cnt_r < CW'(TABLE_SIZE)) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r[IW-1:0];
    end else if (state_r == ST_DRAW) begin
      wr_en   = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    reseed_nxt    = reseed_r;
    out_valid_nxt = out_valid_r && out_stall;
    load_out      = 1'b0;
    load_val      = result;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_func) begin
            a_nxt     = seed_eff;
            b_nxt     = seed_eff;
            cnt_nxt   = CW'(TABLE_SIZE + WARMUP - 1);
            state_nxt = ST_SEED_MUL;
          end else begin
            state_nxt = ST_DRAW;
          end
        end
      end
      ST_SEED_MUL: begin
        state_nxt = ST_SEED_RED;
      end
      ST_SEED_RED: begin
        a_nxt = a_step;
        if (cnt_r == '0) begin
          last_nxt   = a_step;
          reseed_nxt = 1'b1;
          state_nxt  = ST_IDX;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_IDX: begin
        state_nxt = reseed_r ? ST_ISSUE : ST_IDLE;
      end
      ST_ISSUE: begin
        reseed_nxt = 1'b0;
        state_nxt  = ST_DRAW;
      end
      ST_DRAW: begin
        a_nxt    = a_step;
        b_nxt    = b_step;
        last_nxt = result;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDX;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        load_val = pend_r;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDX;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  // hold state, generators and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_r         <= 31'd1;
      b_r         <= B_SEED;
      last_r      <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      reseed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      reseed_r    <= reseed_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_IDX) begin
        idx_r <= idx_nxt;
      end
    end
  end

  // output item and parked deviate
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_deviate_r <= load_val;
    end
    if (state_r == ST_DRAW) begin
      pend_r <= result;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_deviate = out_deviate_r;

endmodule

### rtl/lcgsh_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgsh_step
// Both modular multiplies. The products are registered; the fold by 2^31 mod m
// and the final compare-subtract follow the register, so a result appears in the
// cycle after its operand.
// ----------------------------------------------------------------------------
module lcgsh_step (
  input  logic                 clk,
  input  lcgsh_pkg::word_t     a_in,
  input  lcgsh_pkg::word_t     b_in,
  output lcgsh_pkg::word_t     a_out,
  output lcgsh_pkg::word_t     b_out
);
  import lcgsh_pkg::*;

  logic [46:0] prod_a_r;
  logic [46:0] prod_b_r;
  logic [31:0] sum_a;
  logic [31:0] sum_b;

  // multiply by the generator constants
  always_ff @(posedge clk) begin
    prod_a_r <= {31'd0, MUL_A} * {16'd0, a_in};
    prod_b_r <= {31'd0, MUL_B} * {16'd0, b_in};
  end

  // fold the high part back in, then reduce once
  always_comb begin
    sum_a = ({16'd0, prod_a_r[46:31]} * {24'd0, FOLD_A}) + {1'b0, prod_a_r[30:0]};
    sum_b = ({16'd0, prod_b_r[46:31]} * {24'd0, FOLD_B}) + {1'b0, prod_b_r[30:0]};
  end

  assign a_out = (sum_a >= {1'b0, MOD_A}) ? 31'(sum_a - {1'b0, MOD_A}) : sum_a[30:0];
  assign b_out = (sum_b >= {1'b0, MOD_B}) ? 31'(sum_b - {1'b0, MOD_B}) : sum_b[30:0];

endmodule

### rtl/lcgsh_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgsh_table
// Shuffle table: single-port-write, registered-read memory. A valid bit per
// entry, cleared by reset, makes an unwritten entry read as zero.
// ----------------------------------------------------------------------------
module lcgsh_table #(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
  output lcgsh_pkg::word_t              rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
  input  lcgsh_pkg::word_t              wr_data
);
  import lcgsh_pkg::*;

  word_t                 mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] valid_r;
  word_t                 rd_q_r;
  logic                  rd_vld_r;

  // write and registered read of the array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  // track written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
